>>> rtl/rc4_stream_cipher_macros.svh
// Assertion macros shared by the RC4 stream cipher RTL.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef RC4_STREAM_CIPHER_MACROS_SVH
`define RC4_STREAM_CIPHER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RC4_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RC4_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rc4_pkg.sv
// Shared constants and types for the RC4 stream cipher.
// No dependencies; used by rc4_key_store and rc4_stream_cipher.
package rc4_pkg;

    localparam int KEY_MAX_BYTES_DEF = 256;
    localparam int PERM_DEPTH = 256;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_DATA = 1'b1;

    typedef struct packed {
        logic       en;
        logic       first;
        logic [7:0] value;
    } key_wr_t;

endpackage

>>> rtl/rc4_stream_cipher.sv
// RC4 stream cipher top level: permutation memory, key schedule and keystream sequencer.
// Depends on rc4_pkg, rc4_key_store and rc4_stream_cipher_macros.svh.
//
//   Channel | Ports                                       | Carries
//   --------+---------------------------------------------+--------------------------------
//   input   | s_valid s_ready s_opcode s_byte_value       | key byte or data byte
//           | s_first_of_run                              |
//   result  | m_valid m_ready m_out_byte                  | one byte per data transaction
//
// A key transaction leaves the sequencer idle, and so does a data byte while the key is empty and the output is free.
// A keyed data byte steps through the read-i, read-j, swap and output states on the permutation memory.
// A message start with a non-empty key adds an identity fill of all 256 entries and a key schedule over them.
// Reset clears the indices, the key length and the control; the memories are not cleared.
// A full output register holds the last step until the waiting result is taken.
`include "rc4_stream_cipher_macros.svh"

module rc4_stream_cipher #(
    parameter int KEY_MAX_BYTES = rc4_pkg::KEY_MAX_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_opcode,
    input  logic [7:0] s_byte_value,
    input  logic       s_first_of_run,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte
);
    import rc4_pkg::*;

    localparam int KIDX_W = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
    localparam int KLEN_W = $clog2(KEY_MAX_BYTES + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KS_INIT,
        ST_KS_READ_N,
        ST_KS_READ_J,
        ST_KS_WRITE_N,
        ST_KS_WRITE_J,
        ST_DATA_READ_I,
        ST_DATA_READ_J,
        ST_DATA_SWAP,
        ST_DATA_OUT,
        ST_FINISH
    } state_t;

    state_t            state_reg;
    logic [7:0]        n_reg;
    logic [KIDX_W-1:0] kidx_reg;
    logic [7:0]        i_reg;
    logic [7:0]        j_reg;
    logic [7:0]        si_reg;
    logic [7:0]        sj_reg;
    logic [7:0]        t_reg;
    logic [7:0]        data_reg;
    logic [7:0]        ks_reg;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [7:0]        m_out_byte_reg;

    logic [7:0]        perm_mem [PERM_DEPTH];
    logic [7:0]        perm_rdata_reg;
    logic [7:0]        perm_raddr;
    logic              perm_we;
    logic [7:0]        perm_waddr;
    logic [7:0]        perm_wdata;

    key_wr_t           key_wr;
    logic [7:0]        key_rdata;
    logic [KLEN_W-1:0] key_length;

    logic [7:0]        j_ksa_sum;
    logic [7:0]        j_data_sum;
    logic [7:0]        i_inc;
    logic [7:0]        t_sum;
    logic [7:0]        ks;
    logic              out_free;
    logic              out_load;
    logic              kidx_last;

    assign s_ready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign kidx_last = ((KLEN_W'(kidx_reg) + 1'b1) == key_length);

    always_comb begin
        out_load = out_free &&
                   ((state_reg == ST_IDLE && s_valid && s_opcode == OP_DATA &&
                     key_length == '0) ||
                    state_reg == ST_DATA_OUT || state_reg == ST_FINISH);
        m_valid_next = out_load || (m_valid_reg && !m_ready);
    end

    always_comb begin
        key_wr.en    = s_valid && s_ready && (s_opcode == OP_KEY);
        key_wr.first = s_first_of_run;
        key_wr.value = s_byte_value;
    end

    rc4_key_store #(
        .KEY_MAX_BYTES(KEY_MAX_BYTES),
        .KIDX_W       (KIDX_W),
        .KLEN_W       (KLEN_W)
    ) u_key_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .key_wr    (key_wr),
        .rd_addr   (kidx_reg),
        .rd_data   (key_rdata),
        .key_length(key_length)
    );

    always_comb begin
        j_ksa_sum  = j_reg + perm_rdata_reg + key_rdata;
        j_data_sum = j_reg + perm_rdata_reg;
        i_inc      = i_reg + 8'd1;
        t_sum      = si_reg + perm_rdata_reg;
        perm_raddr = n_reg;
        perm_we    = 1'b0;
        perm_waddr = n_reg;
        perm_wdata = n_reg;
        unique case (state_reg)
            ST_KS_INIT: begin
                perm_we = 1'b1;
            end
            ST_KS_READ_J: begin
                perm_raddr = j_ksa_sum;
            end
            ST_KS_WRITE_N: begin
                perm_we    = 1'b1;
                perm_wdata = perm_rdata_reg;
            end
            ST_KS_WRITE_J: begin
                perm_we    = 1'b1;
                perm_waddr = j_reg;
                perm_wdata = si_reg;
            end
            ST_DATA_READ_I: begin
                perm_raddr = i_inc;
            end
            ST_DATA_READ_J: begin
                perm_raddr = j_data_sum;
            end
            ST_DATA_SWAP: begin
                perm_raddr = t_sum;
                perm_we    = 1'b1;
                perm_waddr = i_reg;
                perm_wdata = perm_rdata_reg;
            end
            ST_DATA_OUT: begin
                perm_we    = 1'b1;
                perm_waddr = j_reg;
                perm_wdata = si_reg;
            end
            default: begin
                perm_we = 1'b0;
            end
        endcase
    end

    // The keystream read overlaps the swap, so entries i and j come from the swap registers.
    always_comb begin
        if (t_reg == j_reg) begin
            ks = si_reg;
        end else if (t_reg == i_reg) begin
            ks = sj_reg;
        end else begin
            ks = perm_rdata_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (perm_we) begin
            perm_mem[perm_waddr] <= perm_wdata;
        end
        perm_rdata_reg <= perm_mem[perm_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            i_reg       <= 8'd0;
            j_reg       <= 8'd0;
            n_reg       <= 8'd0;
            kidx_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_opcode == OP_DATA) begin
                        data_reg <= s_byte_value;
                        if (s_first_of_run) begin
                            i_reg <= 8'd0;
                            j_reg <= 8'd0;
                        end
                        if (key_length == '0) begin
                            if (out_free) begin
                                m_out_byte_reg <= s_byte_value;
                            end else begin
                                ks_reg    <= 8'd0;
                                state_reg <= ST_FINISH;
                            end
                        end else if (s_first_of_run) begin
                            n_reg     <= 8'd0;
                            kidx_reg  <= '0;
                            state_reg <= ST_KS_INIT;
                        end else begin
                            state_reg <= ST_DATA_READ_I;
                        end
                    end
                end
                ST_KS_INIT: begin
                    n_reg <= n_reg + 8'd1;
                    if (n_reg == 8'hFF) begin
                        state_reg <= ST_KS_READ_N;
                    end
                end
                ST_KS_READ_N: begin
                    state_reg <= ST_KS_READ_J;
                end
                ST_KS_READ_J: begin
                    si_reg    <= perm_rdata_reg;
                    j_reg     <= j_ksa_sum;
                    state_reg <= ST_KS_WRITE_N;
                end
                ST_KS_WRITE_N: begin
                    state_reg <= ST_KS_WRITE_J;
                end
                ST_KS_WRITE_J: begin
                    n_reg    <= n_reg + 8'd1;
                    kidx_reg <= kidx_last ? '0 : kidx_reg + 1'b1;
                    if (n_reg == 8'hFF) begin
                        i_reg     <= 8'd0;
                        j_reg     <= 8'd0;
                        state_reg <= ST_DATA_READ_I;
                    end else begin
                        state_reg <= ST_KS_READ_N;
                    end
                end
                ST_DATA_READ_I: begin
                    i_reg     <= i_inc;
                    state_reg <= ST_DATA_READ_J;
                end
                ST_DATA_READ_J: begin
                    si_reg    <= perm_rdata_reg;
                    j_reg     <= j_data_sum;
                    state_reg <= ST_DATA_SWAP;
                end
                ST_DATA_SWAP: begin
                    sj_reg    <= perm_rdata_reg;
                    t_reg     <= t_sum;
                    state_reg <= ST_DATA_OUT;
                end
                ST_DATA_OUT: begin
                    if (out_free) begin
                        m_out_byte_reg <= data_reg ^ ks;
                        state_reg      <= ST_IDLE;
                    end else begin
                        ks_reg    <= ks;
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_out_byte_reg <= data_reg ^ ks_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_out_byte_reg;

    `RC4_ASSERT_NEXT(a_key_one_cycle, s_valid && s_ready && s_opcode == OP_KEY,
                     state_reg == ST_IDLE, "key transaction left the idle state")
    `RC4_ASSERT_SAME(a_ksa_has_key, state_reg == ST_KS_INIT, key_length != '0,
                     "key schedule started with an empty key")
    `RC4_ASSERT_NEXT(a_out_stall, state_reg == ST_DATA_OUT && !out_free,
                     state_reg == ST_FINISH, "stalled result was not parked")
    `RC4_ASSERT_NEXT(a_ksa_done, state_reg == ST_KS_WRITE_J && n_reg == 8'hFF,
                     i_reg == 8'd0 && j_reg == 8'd0, "indices not cleared after the key schedule")

endmodule

>>> rtl/rc4_key_store.sv
// Key byte memory and key length counter for the RC4 stream cipher.
// Depends on rc4_pkg and rc4_stream_cipher_macros.svh.
`include "rc4_stream_cipher_macros.svh"

module rc4_key_store #(
    parameter int KEY_MAX_BYTES = rc4_pkg::KEY_MAX_BYTES_DEF,
    parameter int KIDX_W = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1,
    parameter int KLEN_W = $clog2(KEY_MAX_BYTES + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rc4_pkg::key_wr_t    key_wr,
    input  logic [KIDX_W-1:0]   rd_addr,
    output logic [7:0]          rd_data,
    output logic [KLEN_W-1:0]   key_length
);
    import rc4_pkg::*;

    logic [7:0]        key_mem [KEY_MAX_BYTES];
    logic [7:0]        rd_data_reg;
    logic [KLEN_W-1:0] len_reg;
    logic [KLEN_W-1:0] len_next;
    logic [KLEN_W-1:0] base_len;
    logic              store;

    always_comb begin
        base_len = key_wr.first ? '0 : len_reg;
        store    = key_wr.en && (key_wr.value != 8'd0) &&
                   (base_len < KLEN_W'(KEY_MAX_BYTES));
        len_next = len_reg;
        if (store) begin
            len_next = base_len + 1'b1;
        end else if (key_wr.en) begin
            len_next = base_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (store) begin
            key_mem[base_len[KIDX_W-1:0]] <= key_wr.value;
        end
        rd_data_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else begin
            len_reg <= len_next;
        end
    end

    assign rd_data    = rd_data_reg;
    assign key_length = len_reg;

    `RC4_ASSERT_SAME(a_len_bound, 1'b1, len_reg <= KLEN_W'(KEY_MAX_BYTES), "key length overflow")
    `RC4_ASSERT_NEXT(a_zero_byte, key_wr.en && !key_wr.first && key_wr.value == 8'd0, $stable(len_reg), "zero key byte changed the length")
    `RC4_ASSERT_NEXT(a_first_len, key_wr.en && key_wr.first, len_reg <= KLEN_W'(1), "new key longer than one byte")

endmodule
